// ----- sv/plol_pkg.sv -----
// Shared types, constants and helpers for the price level order list.
// Used by every module of the block but plol_ram; depends on nothing else.
package plol_pkg;

    // Field widths of one input item and one result item.
    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 10;
    localparam int SHARES_W  = 31;
    localparam int VOL_W     = 32;
    localparam int CNT_OUT_W = 11;

    // Default number of order slots in the link memories.
    localparam int ORDER_SLOTS_DEF = 1024;

    // Operation codes carried on s_tuser.
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNLINK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADJUST = 2'd2;

    // Input tdata layout, lowest bit first, padded to whole bytes.
    localparam int S_SLOT_LSB   = 0;
    localparam int S_SHARES_LSB = S_SLOT_LSB + SLOT_W;
    localparam int S_DELTA_LSB  = S_SHARES_LSB + SHARES_W;
    localparam int S_USED_W     = S_DELTA_LSB + VOL_W;
    localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Result tdata layout, lowest bit first, padded to whole bytes.
    localparam int M_VOL_LSB   = 0;
    localparam int M_CNT_LSB   = M_VOL_LSB + VOL_W;
    localparam int M_EMPTY_BIT = M_CNT_LSB + CNT_OUT_W;
    localparam int M_HVAL_BIT  = M_EMPTY_BIT + 1;
    localparam int M_HEAD_LSB  = M_HVAL_BIT + 1;
    localparam int M_TVAL_BIT  = M_HEAD_LSB + SLOT_W;
    localparam int M_TAIL_LSB  = M_TVAL_BIT + 1;
    localparam int M_USED_W    = M_TAIL_LSB + SLOT_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    // One link: a valid flag and the slot it names.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } link_t;

    localparam int LINK_W = $bits(link_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // Take the offered item and start its first step.
        logic execute;  // Finish the item and load the result register.
    } plol_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // The result register can take a new result.
    } plol_sts_t;

    // Signed add that clamps at the 32-bit limits.
    function automatic logic signed [VOL_W-1:0] sat_add(
        input logic signed [VOL_W-1:0] a,
        input logic signed [VOL_W-1:0] b
    );
        logic signed [VOL_W:0] sum;
        sum = {a[VOL_W-1], a} + {b[VOL_W-1], b};
        if (sum[VOL_W] != sum[VOL_W-1]) begin
            sat_add = sum[VOL_W] ? {1'b1, {(VOL_W-1){1'b0}}} : {1'b0, {(VOL_W-1){1'b1}}};
        end else begin
            sat_add = sum[VOL_W-1:0];
        end
    endfunction

endpackage

// ----- sv/plol_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the link memories of the order list.
module plol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/plol_ctrl.sv -----
// Controller of the price level order list: a two-state sequencer.
// Depends on plol_pkg for the command and status types.
module plol_ctrl import plol_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  plol_sts_t sts,
    output plol_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Commands follow directly from the state and the handshakes.
    // No item is taken while reset is held.
    always_comb begin
        cmd.accept  = (state_reg == ST_IDLE) && s_tvalid && aresetn;
        cmd.execute = (state_reg == ST_EXEC) && sts.out_free;
        s_tready    = (state_reg == ST_IDLE) && aresetn;
    end

    // Next state: leave idle on an accepted item, return once the result is loaded.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/plol_datapath.sv -----
// Datapath of the price level order list: link memories, head, tail,
// count, volume and the result register. Depends on plol_pkg and plol_ram.
module plol_datapath import plol_pkg::*; #(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  plol_cmd_t            cmd,
    output plol_sts_t            sts,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(ORDER_SLOTS);
    localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ORDER_SLOTS);

    // A link is usable when it is valid and names a slot that exists.
    function automatic logic link_ok(input link_t l);
        link_ok = l.valid && (32'(l.slot) < 32'(ORDER_SLOTS));
    endfunction

    // Fields of the offered item.
    logic [SLOT_W-1:0] in_slot;
    logic              in_slot_ok;

    // Item captured on accept and held until the next one.
    logic [KIND_W-1:0]   kind_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SHARES_W-1:0] shares_reg;
    logic [VOL_W-1:0]    delta_reg;
    logic                slot_ok_reg;

    // Level state.
    link_t                   head_reg, head_next;
    link_t                   tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [VOL_W-1:0] vol_reg, vol_next;

    // Result register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Link memory ports.
    logic              prev_we, next_we;
    logic [ADDR_W-1:0] prev_wa, next_wa, rd_addr;
    link_t             prev_wd, next_wd;
    logic [LINK_W-1:0] prev_rd, next_rd;
    link_t             p_link, n_link, me_link;

    assign in_slot    = s_tdata[S_SLOT_LSB +: SLOT_W];
    assign in_slot_ok = 32'(in_slot) < 32'(ORDER_SLOTS);
    assign p_link     = link_t'(prev_rd);
    assign n_link     = link_t'(next_rd);
    assign me_link    = '{valid: 1'b1, slot: slot_reg};

    // The read address holds the item's slot while a result stall lasts.
    assign rd_addr = cmd.accept ? ADDR_W'(in_slot) : ADDR_W'(slot_reg);

    plol_ram #(.WIDTH(LINK_W), .DEPTH(ORDER_SLOTS)) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prev_we),
        .wr_addr (prev_wa),
        .wr_data (prev_wd),
        .rd_addr (rd_addr),
        .rd_data (prev_rd)
    );

    plol_ram #(.WIDTH(LINK_W), .DEPTH(ORDER_SLOTS)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    // Operation logic. An append writes the new slot's own links in the
    // accept cycle and the old tail's forward link when it executes.
    // An unlink reads the slot's links in the accept cycle and splices
    // the neighbors when it executes.
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        vol_next   = vol_reg;
        prev_we    = 1'b0;
        prev_wa    = ADDR_W'(in_slot);
        prev_wd    = tail_reg;
        next_we    = 1'b0;
        next_wa    = ADDR_W'(in_slot);
        next_wd    = '0;

        if (cmd.accept && (s_tuser == KIND_APPEND) && in_slot_ok) begin
            prev_we = 1'b1;
            next_we = 1'b1;
        end

        if (cmd.execute) begin
            case (kind_reg)
                KIND_APPEND: begin
                    if (slot_ok_reg) begin
                        vol_next = sat_add(vol_reg, $signed({1'b0, shares_reg}));
                        if (link_ok(tail_reg)) begin
                            next_we = 1'b1;
                            next_wa = ADDR_W'(tail_reg.slot);
                            next_wd = me_link;
                        end else begin
                            head_next = me_link;
                        end
                        tail_next = me_link;
                        if (count_reg != CNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                KIND_UNLINK: begin
                    if (slot_ok_reg) begin
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                        if (link_ok(p_link)) begin
                            next_we = 1'b1;
                            next_wa = ADDR_W'(p_link.slot);
                            next_wd = n_link;
                        end else begin
                            head_next = n_link;
                        end
                        if (link_ok(n_link)) begin
                            prev_we = 1'b1;
                            prev_wa = ADDR_W'(n_link.slot);
                            prev_wd = p_link;
                        end else begin
                            tail_next = p_link;
                        end
                    end
                end
                KIND_ADJUST: begin
                    vol_next = sat_add(vol_reg, $signed(delta_reg));
                end
                default: begin
                end
            endcase
        end
    end

    // Result packing from the state after the operation.
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[M_VOL_LSB +: VOL_W]     = vol_next;
        m_tdata_next[M_CNT_LSB +: CNT_OUT_W] = CNT_OUT_W'(count_next);
        m_tdata_next[M_EMPTY_BIT]            = !head_next.valid;
        m_tdata_next[M_HVAL_BIT]             = head_next.valid;
        m_tdata_next[M_HEAD_LSB +: SLOT_W]   = head_next.valid ? head_next.slot : '0;
        m_tdata_next[M_TVAL_BIT]             = tail_next.valid;
        m_tdata_next[M_TAIL_LSB +: SLOT_W]   = tail_next.valid ? tail_next.slot : '0;
    end

    // Item capture on accept.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg    <= s_tuser;
            slot_reg    <= in_slot;
            shares_reg  <= s_tdata[S_SHARES_LSB +: SHARES_W];
            delta_reg   <= s_tdata[S_DELTA_LSB +: VOL_W];
            slot_ok_reg <= in_slot_ok;
        end
    end

    // Level state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            vol_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            vol_reg   <= vol_next;
            if (cmd.execute) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

endmodule

// ----- sv/price_level_order_list_top.sv -----
// Top level of the price level order list: controller plus datapath.
// Depends on plol_pkg, plol_ctrl and plol_datapath.
//
//   Channel   Direction  Ports                          Carries
//   s_        in         s_tvalid s_tready s_tdata s_tuser  one operation
//   m_        out        m_tvalid m_tready m_tdata          level status
//
// An unlink reads the slot's links in the accept cycle and can write
// the neighbors' links only later, once the registered read data is
// back; an append writes the next-link memory on accept and, with an
// old tail, on execute. No item is taken until the last has executed.
// Reset is synchronous and active low; it clears head, tail, count,
// volume and the result valid, the input is not ready while it is held,
// and the link memories need no clearing pass. A result waiting in the
// output register does not stop the next item from being accepted; that
// item then waits in execute until the result register is free.
module price_level_order_list_top import plol_pkg::*; #(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // order_slot[9:0], order_shares[40:10], volume_delta[72:41], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // total_volume[31:0], order_count[42:32], is_empty[43], head_valid[44],
    // head_slot[54:45], tail_valid[55], tail_slot[65:56], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    plol_cmd_t cmd;
    plol_sts_t sts;

    plol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plol_datapath #(.ORDER_SLOTS(ORDER_SLOTS)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/plol_checker.sv -----
// Port-level checks for the price level order list, bound to the top level.
// Depends on plol_pkg for the result layout.
module plol_checker import plol_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // No result is shown in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Accepting an item moves the controller out of idle, so input is not ready.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted in back-to-back cycles");

    // The empty flag is the inverse of the head valid flag.
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_EMPTY_BIT] != m_tdata[M_HVAL_BIT]))
        else $error("empty flag disagrees with head valid");

    // An absent head reports slot zero.
    a_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_HVAL_BIT] |-> (m_tdata[M_HEAD_LSB +: SLOT_W] == '0))
        else $error("absent head reports a nonzero slot");

endmodule

bind price_level_order_list_top plol_checker u_plol_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/level_status_check.sv -----
// Checker for the price level order list: watches both item channels,
// predicts the level status for every accepted operation and compares.
// Depends on plol_pkg for field widths, layouts, link type and operation codes.
`timescale 1ns / 1ps

module level_status_check import plol_pkg::*; #(
    parameter int LEVEL_SLOTS = ORDER_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // order_slot, order_shares, volume_delta, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [KIND_W-1:0]    s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // total_volume, order_count, is_empty, head_valid, head_slot,
    // tail_valid, tail_slot, zero pad
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   due_count
);

    // Status reported for one item.
    typedef struct {
        logic signed [VOL_W-1:0] volume;
        logic [CNT_OUT_W-1:0]    count;
        logic                    empty;
        logic                    head_ok;
        logic [SLOT_W-1:0]       head;
        logic                    tail_ok;
        logic [SLOT_W-1:0]       tail;
    } level_status_t;

    // Predicted level: link memories, ends of the list, count and volume.
    link_t                   back_link [LEVEL_SLOTS];
    link_t                   fwd_link  [LEVEL_SLOTS];
    link_t                   head_ref;
    link_t                   tail_ref;
    int unsigned             held;
    logic signed [VOL_W-1:0] level_vol;
    level_status_t           status_due [$];

    initial begin
        fail_count = 0;
        due_count  = 0;
        for (int i = 0; i < LEVEL_SLOTS; i++) begin
            back_link[i] = '0;
            fwd_link[i]  = '0;
        end
    end

    // Add two signed volumes and clamp the sum to 32-bit limits.
    function automatic logic signed [VOL_W-1:0] clamp_sum(
        input logic signed [VOL_W-1:0] a,
        input logic signed [VOL_W-1:0] b
    );
        longint sum;
        sum = longint'(a) + longint'(b);
        if (sum > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (sum < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return sum[VOL_W-1:0];
    endfunction

    // A link can be followed only when it is valid and names a real slot.
    function automatic bit names_slot(input link_t l);
        return l.valid && (l.slot < LEVEL_SLOTS);
    endfunction

    // Carry out one operation on the predicted level and report its status.
    function automatic level_status_t advance_level(
        input logic [KIND_W-1:0]     op,
        input logic [SLOT_W-1:0]     slot,
        input logic [SHARES_W-1:0]   shares,
        input logic signed [VOL_W-1:0] delta
    );
        level_status_t st;
        link_t         me;
        link_t         p;
        link_t         n;
        me.valid = 1'b1;
        me.slot  = slot;
        if (op == KIND_APPEND && slot < LEVEL_SLOTS) begin
            level_vol       = clamp_sum(level_vol, $signed({1'b0, shares}));
            back_link[slot] = tail_ref;
            fwd_link[slot]  = '0;
            if (names_slot(tail_ref)) begin
                fwd_link[tail_ref.slot] = me;
            end else begin
                head_ref = me;
            end
            tail_ref = me;
            if (held < LEVEL_SLOTS) held++;
        end else if (op == KIND_UNLINK && slot < LEVEL_SLOTS) begin
            // Splice the slot out; its own links stay as they are.
            p = back_link[slot];
            n = fwd_link[slot];
            if (held > 0) held--;
            if (names_slot(p)) begin
                fwd_link[p.slot] = n;
            end else begin
                head_ref = n;
            end
            if (names_slot(n)) begin
                back_link[n.slot] = p;
            end else begin
                tail_ref = p;
            end
        end else if (op == KIND_ADJUST) begin
            level_vol = clamp_sum(level_vol, delta);
        end
        st.volume  = level_vol;
        st.count   = held[CNT_OUT_W-1:0];
        st.empty   = !head_ref.valid;
        st.head_ok = head_ref.valid;
        st.head    = head_ref.valid ? head_ref.slot : '0;
        st.tail_ok = tail_ref.valid;
        st.tail    = tail_ref.valid ? tail_ref.slot : '0;
        return st;
    endfunction

    task automatic check_field(input string name, input longint want, input longint seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    // Compare each result with the oldest prediction, then predict new items.
    always @(posedge aclk) begin : watch
        level_status_t want;
        level_status_t got;
        int            delta_due;
        delta_due = 0;
        if (!aresetn) begin
            head_ref  = '0;
            tail_ref  = '0;
            held      = 0;
            level_vol = '0;
            status_due.delete();
            due_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                delta_due--;
                if (status_due.size() == 0) begin
                    $error("level status item arrived with no operation waiting");
                    fail_count++;
                end else begin
                    want        = status_due.pop_front();
                    got.volume  = m_tdata[M_VOL_LSB +: VOL_W];
                    got.count   = m_tdata[M_CNT_LSB +: CNT_OUT_W];
                    got.empty   = m_tdata[M_EMPTY_BIT];
                    got.head_ok = m_tdata[M_HVAL_BIT];
                    got.head    = m_tdata[M_HEAD_LSB +: SLOT_W];
                    got.tail_ok = m_tdata[M_TVAL_BIT];
                    got.tail    = m_tdata[M_TAIL_LSB +: SLOT_W];
                    check_field("total_volume", want.volume, got.volume);
                    check_field("order_count", want.count, got.count);
                    check_field("is_empty", want.empty, got.empty);
                    check_field("head_valid", want.head_ok, got.head_ok);
                    check_field("head_slot", want.head, got.head);
                    check_field("tail_valid", want.tail_ok, got.tail_ok);
                    check_field("tail_slot", want.tail, got.tail);
                end
            end
            if (s_tvalid && s_tready) begin
                delta_due++;
                status_due.push_back(advance_level(s_tuser,
                    s_tdata[S_SLOT_LSB +: SLOT_W],
                    s_tdata[S_SHARES_LSB +: SHARES_W],
                    s_tdata[S_DELTA_LSB +: VOL_W]));
            end
            due_count <= due_count + delta_due;
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the price level order list: clock, reset, operation
// stimulus, result back-pressure and the verdict.
// Depends on plol_pkg, price_level_order_list_top and level_status_check.
`timescale 1ns / 1ps

module tb import plol_pkg::*;;

    localparam int                SLOT_COUNT  = ORDER_SLOTS_DEF;
    localparam int                QUIET_LIMIT = 2000;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
    localparam logic [VOL_W-1:0]  VOL_LOW     = 32'h8000_0000;
    localparam logic [VOL_W-1:0]  VOL_HIGH    = 32'h7FFF_FFFF;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   due_count;

    price_level_order_list_top #(.ORDER_SLOTS(SLOT_COUNT)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    level_status_check #(.LEVEL_SLOTS(SLOT_COUNT)) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Result side stalls on a rotating pattern that changes every so often.
    logic [12:0] stall_pat    = '0;
    int unsigned pat_pos      = 0;
    int unsigned epoch_left   = 0;
    bit          always_ready = 1'b0;

    always @(posedge aclk) begin
        if (epoch_left == 0) begin
            epoch_left   <= $urandom_range(20, 200);
            stall_pat    <= 13'($urandom) | 13'(1 << $urandom_range(0, 12));
            always_ready <= ($urandom_range(0, 3) == 0);
        end else begin
            epoch_left <= epoch_left - 1;
        end
        pat_pos  <= (pat_pos == 12) ? 0 : pat_pos + 1;
        m_tready <= always_ready || stall_pat[pat_pos];
    end

    // Watchdog: give up when no item moves on either channel for too long.
    int unsigned quiet = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Slots believed to be linked, slots ever appended, and the order count.
    bit          on_level [SLOT_COUNT];
    bit          seen     [SLOT_COUNT];
    int unsigned level_slots [$];
    int unsigned seen_slots  [$];
    int unsigned level_n     = 0;
    int unsigned burst_left  = 0;

    // Offer one item and hold it until accepted; bursts end in a random gap.
    task automatic offer(
        input logic [KIND_W-1:0]   op,
        input logic [SLOT_W-1:0]   slot,
        input logic [SHARES_W-1:0] shares,
        input logic [VOL_W-1:0]    delta
    );
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_SLOT_LSB +: SLOT_W]     = slot;
        word[S_SHARES_LSB +: SHARES_W] = shares;
        word[S_DELTA_LSB +: VOL_W]     = delta;
        s_tuser  <= op;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    task automatic push_order(input int unsigned slot, input logic [SHARES_W-1:0] shares);
        if (!on_level[slot]) begin
            on_level[slot] = 1'b1;
            level_slots.push_back(slot);
        end
        if (!seen[slot]) begin
            seen[slot] = 1'b1;
            seen_slots.push_back(slot);
        end
        if (level_n < SLOT_COUNT) level_n++;
        offer(KIND_APPEND, SLOT_W'(slot), shares, $urandom);
    endtask

    // Only slots appended at some point are ever unlinked.
    task automatic pull_order(input int unsigned slot);
        if (on_level[slot]) begin
            on_level[slot] = 1'b0;
            foreach (level_slots[i]) begin
                if (level_slots[i] == slot) begin
                    level_slots.delete(i);
                    break;
                end
            end
        end
        if (level_n > 0) level_n--;
        offer(KIND_UNLINK, SLOT_W'(slot), SHARES_W'($urandom), $urandom);
    endtask

    function automatic logic [SHARES_W-1:0] pick_shares();
        case ($urandom_range(0, 19))
            0, 1:    return 31'($urandom);
            2:       return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3:       return VOL_LOW;
            4:       return VOL_HIGH;
            default: return 32'($urandom_range(0, 4000)) - 32'd2000;
        endcase
    endfunction

    function automatic int unsigned free_slot();
        int unsigned s;
        do s = $urandom_range(0, SLOT_COUNT - 1); while (on_level[s]);
        return s;
    endfunction

    // One random operation: mostly proper appends and unlinks, some noise.
    // A proper append needs a free slot, so a full level unlinks instead.
    task automatic mixed_step();
        int unsigned r;
        int unsigned idx;
        r = $urandom_range(0, 99);
        if ((r < 45 || (r < 80 && level_slots.size() == 0))
                && level_slots.size() < SLOT_COUNT) begin
            push_order(free_slot(), pick_shares());
        end else if (r < 80) begin
            case ($urandom_range(0, 2))
                0:       idx = 0;
                1:       idx = level_slots.size() - 1;
                default: idx = $urandom_range(0, level_slots.size() - 1);
            endcase
            pull_order(level_slots[idx]);
        end else if (r < 94) begin
            offer(KIND_ADJUST, SLOT_W'($urandom), SHARES_W'($urandom), pick_delta());
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    // Append a slot that is already on the level.
                    if (level_slots.size() > 0) begin
                        push_order(level_slots[$urandom_range(0, level_slots.size() - 1)],
                                   pick_shares());
                    end else begin
                        offer(KIND_SPARE, SLOT_W'($urandom), SHARES_W'($urandom), $urandom);
                    end
                end
                1: begin
                    // Unlink any slot appended before, linked or not.
                    pull_order(seen_slots[$urandom_range(0, seen_slots.size() - 1)]);
                end
                default: offer(KIND_SPARE, SLOT_W'($urandom), SHARES_W'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        int unsigned full_hits;
        full_hits = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Status of the empty level.
        offer(KIND_ADJUST, SLOT_W'($urandom), SHARES_W'($urandom), '0);
        // Field extremes and saturation of the volume in both directions.
        push_order(0, '0);
        push_order(1023, 31'h7FFF_FFFF);
        push_order(512, 31'd1);
        offer(KIND_ADJUST, '0, '0, VOL_LOW);
        offer(KIND_ADJUST, '1, '1, VOL_LOW);
        offer(KIND_ADJUST, '0, '0, VOL_HIGH);
        offer(KIND_ADJUST, '1, '1, 32'd1);
        // Unlink at the tail, at the head and in the middle.
        pull_order(512);
        pull_order(0);
        push_order(341, 31'd12345);
        push_order(682, '0);
        pull_order(341);
        pull_order(1023);
        pull_order(682);
        // Unlink of a slot no longer linked; the count stays at zero.
        pull_order(682);
        // Unused operation code.
        offer(KIND_SPARE, '1, '1, '1);
        // Append of a slot that is already linked.
        push_order(682, 31'd5);
        push_order(682, 31'd7);
        pull_order(682);

        repeat (400) mixed_step();

        // Fill the level until the count sits at its ceiling for a while.
        while (full_hits < 8) begin
            push_order($urandom_range(0, SLOT_COUNT - 1), pick_shares());
            if (level_n == SLOT_COUNT) full_hits++;
        end

        repeat (150) mixed_step();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && due_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
